// ----- hdl/convex_hull_graham_scan_top_defines.svh -----
// Assertion macros used by the checker file.
`ifndef CONVEX_HULL_GRAHAM_SCAN_TOP_DEFINES_SVH
`define CONVEX_HULL_GRAHAM_SCAN_TOP_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define CHGS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hull block check failed");

// next-cycle implication, checked while out of reset
`define CHGS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hull block check failed");

`endif

// ----- hdl/chgs_pkg.sv -----
// ----------------------------------------------------------------------------
// chgs_pkg
// Types, sizes and helpers for the Graham scan hull block.
// ----------------------------------------------------------------------------
package chgs_pkg;

  localparam int MAX_POINTS = 64;
  localparam int COORD_BITS = 16;
  localparam int IDX_BITS   = $clog2(MAX_POINTS);
  localparam int CNT_BITS   = $clog2(MAX_POINTS + 1);
  localparam int PT_BITS    = 2 * COORD_BITS;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * DIFF_BITS;
  localparam int CROSS_BITS = PROD_BITS + 1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DEGEN = 2'd1;
  localparam logic [1:0] ST_OVF   = 2'd2;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
  } pt_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic                         set_end;
  } in_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] hull_x;
    logic signed [COORD_BITS-1:0] hull_y;
    logic                         hull_end;
    logic [1:0]                   status;
  } out_t;

  // cross product unit status
  typedef struct packed {
    logic done;
    logic pos;
    logic zero;
  } cross_res_t;

  function automatic logic xy_less(pt_t a, pt_t b);
    return (a.x < b.x) || ((a.x == b.x) && (a.y < b.y));
  endfunction

endpackage

// ----- hdl/chgs_ram.sv -----
// ----------------------------------------------------------------------------
// chgs_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module chgs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/chgs_cross.sv -----
// ----------------------------------------------------------------------------
// chgs_cross
// Shared cross product unit: sign of (a-o) x (b-o), one multiplier.
// ----------------------------------------------------------------------------
module chgs_cross (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  chgs_pkg::pt_t       o,
  input  chgs_pkg::pt_t       a,
  input  chgs_pkg::pt_t       b,
  output chgs_pkg::cross_res_t res
);

  typedef enum logic [1:0] {PH_IDLE, PH_MUL1, PH_MUL2, PH_DONE} phase_t;

  phase_t phase;
  logic signed [chgs_pkg::DIFF_BITS-1:0]  dax, day, dbx, dby;
  logic signed [chgs_pkg::PROD_BITS-1:0]  p1, p2;
  logic signed [chgs_pkg::DIFF_BITS-1:0]  mul_a, mul_b;
  logic signed [chgs_pkg::PROD_BITS-1:0]  mul_q;
  logic signed [chgs_pkg::CROSS_BITS-1:0] cross_val;

  // the one multiplier, operands steered by phase
  assign mul_a = (phase == PH_MUL1) ? dax : day;
  assign mul_b = (phase == PH_MUL1) ? dby : dbx;
  assign mul_q = mul_a * mul_b;

  assign cross_val = chgs_pkg::CROSS_BITS'(p1) - chgs_pkg::CROSS_BITS'(p2);
  assign res.done = (phase == PH_DONE);
  assign res.pos  = (cross_val > 0);
  assign res.zero = (cross_val == 0);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else begin
      case (phase)
        PH_IDLE: begin
          if (start) begin
            dax   <= chgs_pkg::DIFF_BITS'(a.x) - chgs_pkg::DIFF_BITS'(o.x);
            day   <= chgs_pkg::DIFF_BITS'(a.y) - chgs_pkg::DIFF_BITS'(o.y);
            dbx   <= chgs_pkg::DIFF_BITS'(b.x) - chgs_pkg::DIFF_BITS'(o.x);
            dby   <= chgs_pkg::DIFF_BITS'(b.y) - chgs_pkg::DIFF_BITS'(o.y);
            phase <= PH_MUL1;
          end
        end
        PH_MUL1: begin
          p1    <= mul_q;
          phase <= PH_MUL2;
        end
        PH_MUL2: begin
          p2    <= mul_q;
          phase <= PH_DONE;
        end
        default: phase <= PH_IDLE;
      endcase
    end
  end

endmodule

// ----- hdl/convex_hull_graham_scan_top.sv -----
// ----------------------------------------------------------------------------
// convex_hull_graham_scan_top
// Convex hull of a point set by Graham scan, exact integer arithmetic.
// ----------------------------------------------------------------------------
// Points are loaded one beat per cycle while pt_stall is low; the beat with
// set_end closes the set and starts the run, and pt_stall stays high until
// the last hull beat has been taken. The run sorts the stored points by x
// then y in place (insertion sort over one point RAM, one cycle per shift),
// drops duplicates, sorts by angle about the pivot with nearer points first
// on collinear ties (insertion sort, each compare waiting on the shared
// cross product unit), then runs the stack scan (each turn test run on the
// cross product unit) and emits the hull counterclockwise from the pivot,
// each beat held while hull_stall is high. More than 64 points gives a
// single overflow beat; one distinct point gives a single degenerate beat.
module convex_hull_graham_scan_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           pt_valid,
  output logic           pt_stall,
  input  chgs_pkg::in_t  pt_data,
  output logic           hull_valid,
  input  logic           hull_stall,
  output chgs_pkg::out_t hull_data
);

  localparam int CB = chgs_pkg::CNT_BITS;
  localparam int IB = chgs_pkg::IDX_BITS;

  typedef enum logic [4:0] {
    S_LOAD,
    S_X_I, S_X_T, S_X_C, S_X_W,      // sort by x then y
    S_D_0, S_D_P, S_D_I, S_D_C,      // duplicate removal
    S_A_I, S_A_T, S_A_C, S_A_WT, S_A_W, // sort by angle
    S_H_INIT, S_H_INIT2, S_H_I, S_H_LD, S_H_TST, S_H_WT, S_H_POP,
    S_E_RD, S_E_LD, S_E_WT
  } state_t;

  state_t state;

  logic [CB-1:0] count, n, i, j, w, sd, k;
  logic          ovf;
  chgs_pkg::pt_t t, b, prev, piv, topp, secp, c;
  logic          elast;

  // point RAM
  logic          pram_we, pram_re;
  logic [IB-1:0] pram_waddr, pram_raddr;
  logic [chgs_pkg::PT_BITS-1:0] pram_wdata, pram_rdata;
  chgs_pkg::pt_t pt_rd;

  // hull stack RAM (holds point values)
  logic          sram_we, sram_re;
  logic [IB-1:0] sram_waddr, sram_raddr;
  logic [chgs_pkg::PT_BITS-1:0] sram_wdata, sram_rdata;
  chgs_pkg::pt_t st_rd;

  // cross unit
  logic                 cx_start;
  chgs_pkg::pt_t        cx_o, cx_a, cx_b;
  chgs_pkg::cross_res_t cres;

  logic [CB-1:0] im1, jm1, jm2, sdm1, sdm3, kp1;
  logic          x_less, a_less, in_fire, out_fire, room;
  chgs_pkg::pt_t in_pt;

  assign im1  = i - CB'(1);
  assign jm1  = j - CB'(1);
  assign jm2  = j - CB'(2);
  assign sdm1 = sd - CB'(1);
  assign sdm3 = sd - CB'(3);
  assign kp1  = k + CB'(1);

  assign pt_rd    = chgs_pkg::pt_t'(pram_rdata);
  assign st_rd    = chgs_pkg::pt_t'(sram_rdata);
  assign in_pt.x  = pt_data.point_x;
  assign in_pt.y  = pt_data.point_y;
  assign pt_stall = (state != S_LOAD);
  assign in_fire  = pt_valid && !pt_stall;
  assign out_fire = hull_valid && !hull_stall;
  assign room     = (count < CB'(chgs_pkg::MAX_POINTS));

  assign x_less = chgs_pkg::xy_less(t, pt_rd);
  // nearer first on a collinear tie: along one ray from the pivot, x/y order
  // is distance order since every point lies lexicographically past the pivot
  assign a_less = cres.pos || (cres.zero && chgs_pkg::xy_less(t, b));

  chgs_ram #(.WIDTH(chgs_pkg::PT_BITS), .DEPTH(chgs_pkg::MAX_POINTS)) u_pram (
    .clk(clk), .we(pram_we), .waddr(pram_waddr), .wdata(pram_wdata),
    .re(pram_re), .raddr(pram_raddr), .rdata(pram_rdata)
  );

  chgs_ram #(.WIDTH(chgs_pkg::PT_BITS), .DEPTH(chgs_pkg::MAX_POINTS)) u_sram (
    .clk(clk), .we(sram_we), .waddr(sram_waddr), .wdata(sram_wdata),
    .re(sram_re), .raddr(sram_raddr), .rdata(sram_rdata)
  );

  chgs_cross u_cross (
    .clk(clk), .rst(rst), .start(cx_start),
    .o(cx_o), .a(cx_a), .b(cx_b), .res(cres)
  );

  // RAM and cross unit control
  always_comb begin
    pram_we    = 1'b0;
    pram_waddr = j[IB-1:0];
    pram_wdata = t;
    pram_re    = 1'b0;
    pram_raddr = i[IB-1:0];
    sram_we    = 1'b0;
    sram_waddr = sd[IB-1:0];
    sram_wdata = c;
    sram_re    = 1'b0;
    sram_raddr = k[IB-1:0];
    cx_start   = 1'b0;
    cx_o       = secp;
    cx_a       = topp;
    cx_b       = c;
    case (state)
      S_LOAD: begin
        pram_we    = in_fire && room;
        pram_waddr = count[IB-1:0];
        pram_wdata = in_pt;
      end
      S_X_I, S_A_I, S_D_I, S_H_I: begin
        pram_re = (i < n);
      end
      S_X_T, S_A_T: begin
        pram_re    = 1'b1;
        pram_raddr = im1[IB-1:0];
      end
      S_X_C: begin
        if (x_less) begin
          pram_we    = 1'b1;
          pram_wdata = pt_rd;
          pram_re    = (j != CB'(1));
          pram_raddr = jm2[IB-1:0];
        end
      end
      S_X_W, S_A_W: begin
        pram_we = 1'b1;
      end
      S_D_0, S_H_INIT: begin
        pram_re    = 1'b1;
        pram_raddr = (state == S_D_0) ? IB'(0) : IB'(1);
        sram_we    = (state == S_H_INIT);
        sram_waddr = IB'(0);
        sram_wdata = piv;
      end
      S_D_C: begin
        pram_we    = (pt_rd != prev);
        pram_waddr = w[IB-1:0];
        pram_wdata = pt_rd;
      end
      S_A_C: begin
        cx_start = 1'b1;
        cx_o     = piv;
        cx_a     = t;
        cx_b     = pt_rd;
      end
      S_A_WT: begin
        if (cres.done && a_less) begin
          pram_we    = 1'b1;
          pram_wdata = b;
          pram_re    = (j != CB'(2));
          pram_raddr = jm2[IB-1:0];
        end
      end
      S_H_INIT2: begin
        sram_we    = 1'b1;
        sram_waddr = IB'(1);
        sram_wdata = pt_rd;
      end
      S_H_TST: begin
        cx_start = (sd >= CB'(2));
        sram_we  = (sd < CB'(2));
      end
      S_H_WT: begin
        if (cres.done) begin
          sram_we    = cres.pos;
          sram_re    = !cres.pos && (sd >= CB'(3));
          sram_raddr = sdm3[IB-1:0];
        end
      end
      S_E_RD: begin
        sram_re = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      count      <= '0;
      ovf        <= 1'b0;
      hull_valid <= 1'b0;
    end else begin
      case (state)
        S_LOAD: begin
          if (in_fire) begin
            if (pt_data.set_end) begin
              count <= '0;
              ovf   <= 1'b0;
              if (ovf || !room) begin
                hull_data  <= '{hull_x: '0, hull_y: '0, hull_end: 1'b1,
                               status: chgs_pkg::ST_OVF};
                hull_valid <= 1'b1;
                elast      <= 1'b1;
                state      <= S_E_WT;
              end else begin
                n     <= count + CB'(1);
                i     <= CB'(1);
                state <= S_X_I;
              end
            end else if (room) begin
              count <= count + CB'(1);
            end else begin
              ovf <= 1'b1;
            end
          end
        end
        // insertion sort by x then y
        S_X_I: state <= (i < n) ? S_X_T : S_D_0;
        S_X_T: begin
          t     <= pt_rd;
          j     <= i;
          state <= S_X_C;
        end
        S_X_C: begin
          if (x_less) begin
            j <= jm1;
            if (j == CB'(1)) begin
              state <= S_X_W;
            end
          end else begin
            state <= S_X_W;
          end
        end
        S_X_W: begin
          i     <= i + CB'(1);
          state <= S_X_I;
        end
        // drop duplicates; the first survivor is the pivot
        S_D_0: begin
          i     <= CB'(1);
          w     <= CB'(1);
          state <= S_D_P;
        end
        S_D_P: begin
          prev  <= pt_rd;
          piv   <= pt_rd;
          state <= S_D_I;
        end
        S_D_I: begin
          if (i < n) begin
            state <= S_D_C;
          end else if (w < CB'(2)) begin
            hull_data  <= '{hull_x: piv.x, hull_y: piv.y, hull_end: 1'b1,
                           status: chgs_pkg::ST_DEGEN};
            hull_valid <= 1'b1;
            elast      <= 1'b1;
            state      <= S_E_WT;
          end else begin
            n     <= w;
            i     <= CB'(2);
            state <= S_A_I;
          end
        end
        S_D_C: begin
          if (pt_rd != prev) begin
            prev <= pt_rd;
            w    <= w + CB'(1);
          end
          i     <= i + CB'(1);
          state <= S_D_I;
        end
        // insertion sort by angle about the pivot
        S_A_I: state <= (i < n) ? S_A_T : S_H_INIT;
        S_A_T: begin
          t     <= pt_rd;
          j     <= i;
          state <= S_A_C;
        end
        S_A_C: begin
          b     <= pt_rd;
          state <= S_A_WT;
        end
        S_A_WT: begin
          if (cres.done) begin
            if (a_less) begin
              j     <= jm1;
              state <= (j == CB'(2)) ? S_A_W : S_A_C;
            end else begin
              state <= S_A_W;
            end
          end
        end
        S_A_W: begin
          i     <= i + CB'(1);
          state <= S_A_I;
        end
        // stack scan; top two entries mirrored in topp and secp
        S_H_INIT: state <= S_H_INIT2;
        S_H_INIT2: begin
          topp  <= pt_rd;
          secp  <= piv;
          sd    <= CB'(2);
          i     <= CB'(2);
          state <= S_H_I;
        end
        S_H_I: begin
          if (i < n) begin
            state <= S_H_LD;
          end else begin
            k     <= '0;
            state <= S_E_RD;
          end
        end
        S_H_LD: begin
          c     <= pt_rd;
          state <= S_H_TST;
        end
        S_H_TST: begin
          if (sd >= CB'(2)) begin
            state <= S_H_WT;
          end else begin
            secp  <= topp;
            topp  <= c;
            sd    <= sd + CB'(1);
            i     <= i + CB'(1);
            state <= S_H_I;
          end
        end
        S_H_WT: begin
          if (cres.done) begin
            if (cres.pos) begin
              secp  <= topp;
              topp  <= c;
              sd    <= sd + CB'(1);
              i     <= i + CB'(1);
              state <= S_H_I;
            end else begin
              sd    <= sdm1;
              topp  <= secp;
              state <= (sd >= CB'(3)) ? S_H_POP : S_H_TST;
            end
          end
        end
        S_H_POP: begin
          secp  <= st_rd;
          state <= S_H_TST;
        end
        // emit hull beats from the stack bottom up
        S_E_RD: state <= S_E_LD;
        S_E_LD: begin
          hull_data.hull_x   <= st_rd.x;
          hull_data.hull_y   <= st_rd.y;
          hull_data.hull_end <= (kp1 == sd);
          hull_data.status   <= chgs_pkg::ST_OK;
          elast              <= (kp1 == sd);
          hull_valid         <= 1'b1;
          state              <= S_E_WT;
        end
        S_E_WT: begin
          if (out_fire) begin
            hull_valid <= 1'b0;
            k          <= kp1;
            state      <= elast ? S_LOAD : S_E_RD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

endmodule

// ----- hdl/chgs_checker.sv -----
// ----------------------------------------------------------------------------
// chgs_checker
// Port-level checks on the hull block, bound to the top level.
// ----------------------------------------------------------------------------
`include "convex_hull_graham_scan_top_defines.svh"

module chgs_checker (
  input logic           clk,
  input logic           rst,
  input logic           pt_valid,
  input logic           pt_stall,
  input chgs_pkg::in_t  pt_data,
  input logic           hull_valid,
  input logic           hull_stall,
  input chgs_pkg::out_t hull_data
);

  `CHGS_ASSERT_NEXT(a_hold, hull_valid && hull_stall, hull_valid && $stable(hull_data))
  `CHGS_ASSERT_NOW(a_busy, hull_valid, pt_stall)
  `CHGS_ASSERT_NOW(a_stat_end, hull_valid && (hull_data.status != chgs_pkg::ST_OK), hull_data.hull_end)
  `CHGS_ASSERT_NEXT(a_run, pt_valid && !pt_stall && pt_data.set_end, pt_stall)

endmodule

bind convex_hull_graham_scan_top chgs_checker u_chgs_checker (.*);
